>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared same-cycle and next-cycle implication property forms
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define LPN_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lpn same-cycle check failed");

// next-cycle implication
`define LPN_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lpn next-cycle check failed");

`endif

>>> hdl/lpn_pkg.sv
// ----------------------------------------------------------------------------
// lpn_pkg
// types, constants and the arctangent table of the line-of-sight guidance core
// ----------------------------------------------------------------------------
package lpn_pkg;

   localparam int ANGLE_BITS = 16;
   localparam int PIXEL_BITS = 12;
   localparam int CORDIC_W   = 34;
   localparam int TRIG_W     = 18;
   localparam int TAB_BITS   = 5;
   localparam int MUL_A_W    = 36;
   localparam int MUL_B_W    = 18;
   localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
   localparam int MAT_W      = 35;
   localparam int NVEC_W     = 50;

   // register indexes of the configuration port
   localparam logic [1:0] CSR_NAV_GAIN     = 2'd0;
   localparam logic [1:0] CSR_FOCAL_PIXELS = 2'd1;
   localparam logic [1:0] CSR_INVERSE_STEP = 2'd2;

   typedef struct packed {
      logic signed [PIXEL_BITS-1:0] pixel_err_x;
      logic signed [PIXEL_BITS-1:0] pixel_err_y;
      logic signed [15:0]           quat_w;
      logic signed [15:0]           quat_x;
      logic signed [15:0]           quat_y;
      logic signed [15:0]           quat_z;
   } lpn_req_type;

   typedef struct packed {
      logic signed [31:0] rate_azimuth;
      logic signed [31:0] rate_elevation;
      logic signed [15:0] los_azimuth;
      logic signed [15:0] los_elevation;
      logic signed [15:0] lead_azimuth;
      logic signed [15:0] lead_elevation;
      logic signed [15:0] dir_east;
      logic signed [15:0] dir_north;
      logic signed [15:0] dir_up;
      logic               priming;
   } lpn_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_QUAT,
      ST_MATRIX,
      ST_NORM,
      ST_AZIM,
      ST_HORIZ,
      ST_ELEV,
      ST_LEAD,
      ST_TRIG_AZ,
      ST_TRIG_EL,
      ST_DIR,
      ST_OUT
   } lpn_state_type;

   typedef struct packed {
      logic start;
      logic rotate;
   } lpn_cordic_cmd_type;

   // atan(2^-i) as a 32 bit binary angle
   function automatic logic [31:0] atan_entry(input logic [TAB_BITS-1:0] idx);
      logic [31:0] r;
      case (idx)
         5'd0:  r = 32'h20000000;
         5'd1:  r = 32'h12E4051E;
         5'd2:  r = 32'h09FB385B;
         5'd3:  r = 32'h051111D4;
         5'd4:  r = 32'h028B0D43;
         5'd5:  r = 32'h0145D7E1;
         5'd6:  r = 32'h00A2F61E;
         5'd7:  r = 32'h00517C55;
         5'd8:  r = 32'h0028BE53;
         5'd9:  r = 32'h00145F2F;
         5'd10: r = 32'h000A2F98;
         5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6;
         5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2FA;
         5'd15: r = 32'h0000517D;
         5'd16: r = 32'h000028BE;
         5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A30;
         5'd19: r = 32'h00000518;
         5'd20: r = 32'h0000028C;
         5'd21: r = 32'h00000146;
         5'd22: r = 32'h000000A3;
         5'd23: r = 32'h00000051;
         default: r = 32'h00000000;
      endcase
      return r;
   endfunction

endpackage

>>> hdl/lpn_mul.sv
// ----------------------------------------------------------------------------
// lpn_mul
// shared signed multiplier with a registered product
// ----------------------------------------------------------------------------
module lpn_mul import lpn_pkg::*; (
   input  logic                      clock,
   input  logic signed [MUL_A_W-1:0] op_a,
   input  logic signed [MUL_B_W-1:0] op_b,
   output logic signed [MUL_P_W-1:0] product
);

   logic signed [MUL_P_W-1:0] prod_ff;
   logic signed [MUL_P_W-1:0] prod_in;

   // full-width signed product
   assign prod_in = MUL_P_W'(op_a) * MUL_P_W'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign product = prod_ff;

endmodule

>>> hdl/lpn_cordic.sv
// ----------------------------------------------------------------------------
// lpn_cordic
// shared cordic unit, one iteration per cycle, vectoring or rotation mode
// ----------------------------------------------------------------------------
module lpn_cordic import lpn_pkg::*; #(
   parameter int STEPS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  lpn_cordic_cmd_type         cmd,
   input  logic signed [CORDIC_W-1:0] vec_x,
   input  logic signed [CORDIC_W-1:0] vec_y,
   input  logic [ANGLE_BITS-1:0]      angle,
   output logic                       done,
   output logic signed [CORDIC_W-1:0] magnitude,
   output logic [31:0]                phase,
   output logic signed [TRIG_W-1:0]   cos_out,
   output logic signed [TRIG_W-1:0]   sin_out
);

   localparam logic signed [CORDIC_W-1:0] HALF_TURN = CORDIC_W'(64'h80000000);
   localparam logic signed [CORDIC_W-1:0] INV_GAIN  = CORDIC_W'(652032874);
   localparam logic signed [CORDIC_W-1:0] ROUND_Q14 = CORDIC_W'(32768);

   logic signed [CORDIC_W-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [TAB_BITS-1:0]        i_ff, i_in;
   logic                       busy_ff, busy_in, done_ff, done_in;
   logic                       rot_ff, rot_in, neg_ff, neg_in;

   logic signed [CORDIC_W-1:0] dx, dy, at, cx, cy;
   logic                       up, add_x;
   logic [31:0]                t0, tq, tt;

   // one micro-rotation
   assign dx    = y_ff >>> i_ff;
   assign dy    = x_ff >>> i_ff;
   assign at    = CORDIC_W'({2'b00, atan_entry(i_ff)});
   assign up    = rot_ff ? !z_ff[CORDIC_W-1] : !y_ff[CORDIC_W-1];
   assign add_x = up ^ rot_ff;

   // fold the start angle into the right half plane
   assign t0 = {angle, {(32-ANGLE_BITS){1'b0}}};
   assign tq = t0 + 32'h40000000;
   assign tt = tq[31] ? t0 + 32'h80000000 : t0;

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      i_in    = i_ff;
      busy_in = busy_ff;
      rot_in  = rot_ff;
      neg_in  = neg_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         i_in   = '0;
         rot_in = cmd.rotate;
         if (cmd.rotate) begin
            x_in    = INV_GAIN;
            y_in    = '0;
            z_in    = CORDIC_W'(signed'(tt));
            neg_in  = tq[31];
            busy_in = 1'b1;
         end else if (vec_x == '0 && vec_y == '0) begin
            // zero vector gives angle zero and no iterations
            x_in    = '0;
            y_in    = '0;
            z_in    = '0;
            neg_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            x_in    = vec_x[CORDIC_W-1] ? -vec_x : vec_x;
            y_in    = vec_x[CORDIC_W-1] ? -vec_y : vec_y;
            z_in    = vec_x[CORDIC_W-1] ? HALF_TURN : '0;
            neg_in  = 1'b0;
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         x_in = add_x ? x_ff + dx : x_ff - dx;
         y_in = add_x ? y_ff - dy : y_ff + dy;
         z_in = add_x ? z_ff + at : z_ff - at;
         i_in = i_ff + 1'b1;
         if (i_ff == TAB_BITS'(STEPS-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      i_ff   <= i_in;
      rot_ff <= rot_in;
      neg_ff <= neg_in;
   end

   // results, sin and cos rounded to q14
   assign cx        = neg_ff ? -x_ff : x_ff;
   assign cy        = neg_ff ? -y_ff : y_ff;
   assign done      = done_ff;
   assign magnitude = x_ff;
   assign phase     = z_ff[31:0];
   assign cos_out   = TRIG_W'((cx + ROUND_Q14) >>> 16);
   assign sin_out   = TRIG_W'((cy + ROUND_Q14) >>> 16);

endmodule

>>> hdl/image_los_proportional_navigation_core.sv
// ----------------------------------------------------------------------------
// image_los_proportional_navigation_core
// line-of-sight angles from a pixel error and attitude, proportional navigation
// ----------------------------------------------------------------------------
// channel   direction  handshake               payload
// req       in         req_valid / req_ready   lpn_req_type
// rsp       out        rsp_valid / rsp_ready   lpn_rsp_type
// csr       in         csr_valid / csr_ready   csr_index, csr_data
//
// one transaction at a time; the shared cordic unit and the shared multiplier
// run every step in turn, and each normalizing shift adds to the time from
// acceptance to the result.
// req_ready is high only while idle; a finished result waits in the output
// register, and a new item is taken while it waits. csr writes are always taken.
// reset restores the register defaults and clears the priming state.
// ----------------------------------------------------------------------------
module image_los_proportional_navigation_core import lpn_pkg::*; #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  lpn_req_type req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output lpn_rsp_type rsp_payload,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam logic signed [MAT_W-1:0]  ONE_Q28  = MAT_W'(268435456);
   localparam logic signed [NVEC_W-1:0] NORM_LIM = NVEC_W'(536870912);
   localparam logic signed [MUL_B_W-1:0] INV_GAIN_Q14 = MUL_B_W'(9949);

   // sequencer and configuration
   lpn_state_type state_ff, state_in;
   logic          ph_ff, ph_in;
   logic [3:0]    idx_ff, idx_in;
   logic [15:0]   nav_gain_ff, nav_gain_in;
   logic [11:0]   focal_ff, focal_in;
   logic [13:0]   inv_step_ff, inv_step_in;
   logic          primed_ff, primed_in;
   logic [15:0]   last_az_ff, last_az_in, last_el_ff, last_el_in;
   logic [15:0]   last_lead_az_ff, last_lead_az_in, last_lead_el_ff, last_lead_el_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // datapath
   lpn_req_type                 req_ff, req_in;
   logic signed [31:0]          p_ff [9];
   logic signed [31:0]          p_in [9];
   logic signed [NVEC_W-1:0]    n_ff [3];
   logic signed [NVEC_W-1:0]    n_in [3];
   logic [2:0]                  drop_ff, drop_in;
   logic signed [CORDIC_W-1:0]  h_ff, h_in;
   logic [15:0]                 az_ff, az_in, el_ff, el_in;
   logic [15:0]                 lead_az_ff, lead_az_in, lead_el_ff, lead_el_in;
   logic signed [31:0]          rate_az_ff, rate_az_in, rate_el_ff, rate_el_in;
   logic signed [TRIG_W-1:0]    ca_ff, ca_in, sa_ff, sa_in, ce_ff, ce_in, se_ff, se_in;
   logic signed [15:0]          dir_e_ff, dir_e_in, dir_n_ff, dir_n_in;
   lpn_rsp_type                 rsp_ff, rsp_in;

   // shared units
   logic signed [MUL_A_W-1:0]   mul_a;
   logic signed [MUL_B_W-1:0]   mul_b;
   logic signed [MUL_P_W-1:0]   mul_p, mul_r12, mul_r14;
   lpn_cordic_cmd_type          cmd;
   logic signed [CORDIC_W-1:0]  cor_x, cor_y, cor_mag;
   logic [ANGLE_BITS-1:0]       cor_angle;
   logic                        cor_done;
   logic [31:0]                 cor_phase;
   logic signed [TRIG_W-1:0]    cor_cos, cor_sin;

   // operand selection
   logic signed [15:0]          q_a, q_b;
   logic signed [MAT_W-1:0]     m_ent;
   logic signed [12:0]          b_sel, b0, b1, b2;
   logic [1:0]                  row;
   logic signed [15:0]          da, de;
   logic signed [MUL_B_W-1:0]   gain_op, inv_op;
   logic                        big;

   function automatic logic signed [15:0] clamp_q14(input logic signed [39:0] v);
      logic signed [15:0] r;
      if (v > 40'sd16384) r = 16'sd16384;
      else if (v < -40'sd16384) r = -16'sd16384;
      else r = 16'(v);
      return r;
   endfunction

   function automatic logic [ANGLE_BITS-1:0] to_bin(input logic [31:0] z);
      logic [31:0] r;
      r = z + (32'd1 << (31 - ANGLE_BITS));
      return r[31 -: ANGLE_BITS];
   endfunction

   lpn_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (mul_p)
   );

   lpn_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .vec_x     (cor_x),
      .vec_y     (cor_y),
      .angle     (cor_angle),
      .done      (cor_done),
      .magnitude (cor_mag),
      .phase     (cor_phase),
      .cos_out   (cor_cos),
      .sin_out   (cor_sin)
   );

   // ray in the body frame: (f, -x, -y)
   assign b0 = signed'({1'b0, focal_ff});
   assign b1 = -13'(req_ff.pixel_err_x);
   assign b2 = -13'(req_ff.pixel_err_y);

   assign gain_op = signed'({2'b00, nav_gain_ff});
   assign inv_op  = signed'({4'b0000, inv_step_ff});
   assign da      = signed'(az_ff - last_az_ff);
   assign de      = signed'(el_ff - last_el_ff);
   assign mul_r12 = mul_p + MUL_P_W'(2048);
   assign mul_r14 = mul_p + MUL_P_W'(8192);

   // any component whose unshifted magnitude, shifted down, is at or above 2^29
   // a negative value at exactly -2^29 counts only when no set bit was dropped
   always_comb begin
      big = 1'b0;
      for (int k = 0; k < 3; k++) begin
         if (n_ff[k] >= NORM_LIM || n_ff[k] < -NORM_LIM ||
             (n_ff[k] == -NORM_LIM && !drop_ff[k])) big = 1'b1;
      end
   end

   // quaternion product pairs
   always_comb begin
      case (idx_ff)
         4'd0:    begin q_a = req_ff.quat_y; q_b = req_ff.quat_y; end
         4'd1:    begin q_a = req_ff.quat_z; q_b = req_ff.quat_z; end
         4'd2:    begin q_a = req_ff.quat_x; q_b = req_ff.quat_x; end
         4'd3:    begin q_a = req_ff.quat_x; q_b = req_ff.quat_y; end
         4'd4:    begin q_a = req_ff.quat_z; q_b = req_ff.quat_w; end
         4'd5:    begin q_a = req_ff.quat_x; q_b = req_ff.quat_z; end
         4'd6:    begin q_a = req_ff.quat_y; q_b = req_ff.quat_w; end
         4'd7:    begin q_a = req_ff.quat_y; q_b = req_ff.quat_z; end
         4'd8:    begin q_a = req_ff.quat_x; q_b = req_ff.quat_w; end
         default: begin q_a = '0; q_b = '0; end
      endcase
   end

   // rotation matrix entry (q2.28), ray component and target row
   always_comb begin
      case (idx_ff)
         4'd0: begin
            m_ent = ONE_Q28 - ((MAT_W'(p_ff[0]) + MAT_W'(p_ff[1])) <<< 1);
            b_sel = b0; row = 2'd0;
         end
         4'd1: begin
            m_ent = (MAT_W'(p_ff[3]) - MAT_W'(p_ff[4])) <<< 1;
            b_sel = b1; row = 2'd0;
         end
         4'd2: begin
            m_ent = (MAT_W'(p_ff[5]) + MAT_W'(p_ff[6])) <<< 1;
            b_sel = b2; row = 2'd0;
         end
         4'd3: begin
            m_ent = (MAT_W'(p_ff[3]) + MAT_W'(p_ff[4])) <<< 1;
            b_sel = b0; row = 2'd1;
         end
         4'd4: begin
            m_ent = ONE_Q28 - ((MAT_W'(p_ff[2]) + MAT_W'(p_ff[1])) <<< 1);
            b_sel = b1; row = 2'd1;
         end
         4'd5: begin
            m_ent = (MAT_W'(p_ff[7]) - MAT_W'(p_ff[8])) <<< 1;
            b_sel = b2; row = 2'd1;
         end
         4'd6: begin
            m_ent = (MAT_W'(p_ff[5]) - MAT_W'(p_ff[6])) <<< 1;
            b_sel = b0; row = 2'd2;
         end
         4'd7: begin
            m_ent = (MAT_W'(p_ff[7]) + MAT_W'(p_ff[8])) <<< 1;
            b_sel = b1; row = 2'd2;
         end
         4'd8: begin
            m_ent = ONE_Q28 - ((MAT_W'(p_ff[2]) + MAT_W'(p_ff[0])) <<< 1);
            b_sel = b2; row = 2'd2;
         end
         default: begin
            m_ent = '0; b_sel = '0; row = 2'd0;
         end
      endcase
   end

   // sequencer: next state, shared unit operands, datapath updates
   always_comb begin
      state_in        = state_ff;
      ph_in           = ph_ff;
      idx_in          = idx_ff;
      nav_gain_in     = nav_gain_ff;
      focal_in        = focal_ff;
      inv_step_in     = inv_step_ff;
      primed_in       = primed_ff;
      last_az_in      = last_az_ff;
      last_el_in      = last_el_ff;
      last_lead_az_in = last_lead_az_ff;
      last_lead_el_in = last_lead_el_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      req_in          = req_ff;
      p_in            = p_ff;
      n_in            = n_ff;
      drop_in         = drop_ff;
      h_in            = h_ff;
      az_in           = az_ff;
      el_in           = el_ff;
      lead_az_in      = lead_az_ff;
      lead_el_in      = lead_el_ff;
      rate_az_in      = rate_az_ff;
      rate_el_in      = rate_el_ff;
      ca_in           = ca_ff;
      sa_in           = sa_ff;
      ce_in           = ce_ff;
      se_in           = se_ff;
      dir_e_in        = dir_e_ff;
      dir_n_in        = dir_n_ff;
      rsp_in          = rsp_ff;
      mul_a           = '0;
      mul_b           = '0;
      cmd             = '0;
      cor_x           = '0;
      cor_y           = '0;
      cor_angle       = '0;

      // configuration writes
      if (csr_valid) begin
         case (csr_index)
            CSR_NAV_GAIN:     nav_gain_in = csr_data;
            CSR_FOCAL_PIXELS: focal_in    = csr_data[11:0];
            CSR_INVERSE_STEP: inv_step_in = csr_data[13:0];
            default:          ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_payload;
               n_in     = '{default: '0};
               drop_in  = '0;
               idx_in   = '0;
               ph_in    = 1'b0;
               state_in = ST_QUAT;
            end
         end

         // nine quaternion products
         ST_QUAT: begin
            if (!ph_ff) begin
               mul_a = MUL_A_W'(q_a);
               mul_b = MUL_B_W'(q_b);
               ph_in = 1'b1;
            end else begin
               p_in[idx_ff] = mul_p[31:0];
               ph_in        = 1'b0;
               if (idx_ff == 4'd8) begin
                  idx_in   = '0;
                  state_in = ST_MATRIX;
               end else begin
                  idx_in = idx_ff + 4'd1;
               end
            end
         end

         // world vector, one matrix entry times one ray component a step
         ST_MATRIX: begin
            if (!ph_ff) begin
               mul_a = MUL_A_W'(m_ent);
               mul_b = MUL_B_W'(b_sel);
               ph_in = 1'b1;
            end else begin
               n_in[row] = n_ff[row] + NVEC_W'(mul_p);
               ph_in     = 1'b0;
               if (idx_ff == 4'd8) begin
                  idx_in   = '0;
                  state_in = ST_NORM;
               end else begin
                  idx_in = idx_ff + 4'd1;
               end
            end
         end

         // shift down one bit a cycle until all components fit
         ST_NORM: begin
            if (big) begin
               for (int k = 0; k < 3; k++) begin
                  n_in[k]    = n_ff[k] >>> 1;
                  drop_in[k] = drop_ff[k] | n_ff[k][0];
               end
            end else begin
               state_in = ST_AZIM;
            end
         end

         // azimuth = atan2(east, north)
         ST_AZIM: begin
            if (!ph_ff) begin
               cmd.start = 1'b1;
               cor_x     = CORDIC_W'(n_ff[1]);
               cor_y     = CORDIC_W'(n_ff[0]);
               ph_in     = 1'b1;
            end else if (cor_done) begin
               az_in    = to_bin(cor_phase);
               ph_in    = 1'b0;
               state_in = ST_HORIZ;
            end
         end

         // horizontal magnitude, cordic gain removed
         ST_HORIZ: begin
            if (!ph_ff) begin
               mul_a = MUL_A_W'(cor_mag);
               mul_b = INV_GAIN_Q14;
               ph_in = 1'b1;
            end else begin
               h_in     = CORDIC_W'(mul_p >>> 14);
               ph_in    = 1'b0;
               state_in = ST_ELEV;
            end
         end

         // elevation = atan2(up, horizontal)
         ST_ELEV: begin
            if (!ph_ff) begin
               cmd.start = 1'b1;
               cor_x     = h_ff;
               cor_y     = CORDIC_W'(n_ff[2]);
               ph_in     = 1'b1;
            end else if (cor_done) begin
               el_in    = to_bin(cor_phase);
               ph_in    = 1'b0;
               idx_in   = '0;
               state_in = ST_LEAD;
            end
         end

         // rates and lead angle increments
         ST_LEAD: begin
            if (!ph_ff) begin
               case (idx_ff)
                  4'd0:    begin mul_a = MUL_A_W'(da); mul_b = inv_op; end
                  4'd1:    begin mul_a = MUL_A_W'(de); mul_b = inv_op; end
                  4'd2:    begin mul_a = MUL_A_W'(da); mul_b = gain_op; end
                  4'd3:    begin mul_a = MUL_A_W'(de); mul_b = gain_op; end
                  default: begin mul_a = '0; mul_b = '0; end
               endcase
               ph_in = 1'b1;
            end else begin
               // rate magnitude stays below 2^29, no saturation reachable
               case (idx_ff)
                  4'd0: rate_az_in = mul_p[31:0];
                  4'd1: rate_el_in = mul_p[31:0];
                  4'd2: lead_az_in = primed_ff ? last_lead_az_ff + mul_r12[27:12] : az_ff;
                  4'd3: lead_el_in = primed_ff ? last_lead_el_ff + mul_r12[27:12] : el_ff;
                  default: ;
               endcase
               ph_in = 1'b0;
               if (idx_ff == 4'd3) begin
                  idx_in   = '0;
                  state_in = ST_TRIG_AZ;
               end else begin
                  idx_in = idx_ff + 4'd1;
               end
            end
         end

         ST_TRIG_AZ: begin
            if (!ph_ff) begin
               cmd.start  = 1'b1;
               cmd.rotate = 1'b1;
               cor_angle  = lead_az_ff;
               ph_in      = 1'b1;
            end else if (cor_done) begin
               ca_in    = cor_cos;
               sa_in    = cor_sin;
               ph_in    = 1'b0;
               state_in = ST_TRIG_EL;
            end
         end

         ST_TRIG_EL: begin
            if (!ph_ff) begin
               cmd.start  = 1'b1;
               cmd.rotate = 1'b1;
               cor_angle  = lead_el_ff;
               ph_in      = 1'b1;
            end else if (cor_done) begin
               ce_in    = cor_cos;
               se_in    = cor_sin;
               ph_in    = 1'b0;
               idx_in   = '0;
               state_in = ST_DIR;
            end
         end

         // horizontal direction products, q28 rounded to q14
         ST_DIR: begin
            if (!ph_ff) begin
               mul_a = MUL_A_W'(ce_ff);
               mul_b = (idx_ff == 4'd0) ? sa_ff : ca_ff;
               ph_in = 1'b1;
            end else begin
               if (idx_ff == 4'd0) begin
                  dir_e_in = clamp_q14(40'(mul_r14 >>> 14));
                  idx_in   = 4'd1;
               end else begin
                  dir_n_in = clamp_q14(40'(mul_r14 >>> 14));
                  idx_in   = '0;
                  state_in = ST_OUT;
               end
               ph_in = 1'b0;
            end
         end

         // hand off to the output register and commit state
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.rate_azimuth   = primed_ff ? rate_az_ff : '0;
               rsp_in.rate_elevation = primed_ff ? rate_el_ff : '0;
               rsp_in.los_azimuth    = signed'(az_ff);
               rsp_in.los_elevation  = signed'(el_ff);
               rsp_in.lead_azimuth   = signed'(lead_az_ff);
               rsp_in.lead_elevation = signed'(lead_el_ff);
               rsp_in.dir_east       = dir_e_ff;
               rsp_in.dir_north      = dir_n_ff;
               rsp_in.dir_up         = clamp_q14(40'(se_ff));
               rsp_in.priming        = !primed_ff;
               rsp_valid_in          = 1'b1;
               last_az_in            = az_ff;
               last_el_in            = el_ff;
               last_lead_az_in       = lead_az_ff;
               last_lead_el_in       = lead_el_ff;
               primed_in             = 1'b1;
               state_in              = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         ph_ff           <= 1'b0;
         idx_ff          <= '0;
         nav_gain_ff     <= 16'd8192;
         focal_ff        <= 12'd554;
         inv_step_ff     <= 14'd100;
         primed_ff       <= 1'b0;
         last_az_ff      <= '0;
         last_el_ff      <= '0;
         last_lead_az_ff <= '0;
         last_lead_el_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         ph_ff           <= ph_in;
         idx_ff          <= idx_in;
         nav_gain_ff     <= nav_gain_in;
         focal_ff        <= focal_in;
         inv_step_ff     <= inv_step_in;
         primed_ff       <= primed_in;
         last_az_ff      <= last_az_in;
         last_el_ff      <= last_el_in;
         last_lead_az_ff <= last_lead_az_in;
         last_lead_el_ff <= last_lead_el_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      p_ff       <= p_in;
      n_ff       <= n_in;
      drop_ff    <= drop_in;
      h_ff       <= h_in;
      az_ff      <= az_in;
      el_ff      <= el_in;
      lead_az_ff <= lead_az_in;
      lead_el_ff <= lead_el_in;
      rate_az_ff <= rate_az_in;
      rate_el_ff <= rate_el_in;
      ca_ff      <= ca_in;
      sa_ff      <= sa_in;
      ce_ff      <= ce_in;
      se_ff      <= se_in;
      dir_e_ff   <= dir_e_in;
      dir_n_ff   <= dir_n_in;
      rsp_ff     <= rsp_in;
   end

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign csr_ready   = 1'b1;

endmodule

>>> hdl/lpn_checker.sv
// ----------------------------------------------------------------------------
// lpn_checker
// port-level checks of the guidance core, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lpn_checker import lpn_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input lpn_req_type req_payload,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input lpn_rsp_type rsp_payload,
   input logic        csr_valid,
   input logic        csr_ready,
   input logic [1:0]  csr_index,
   input logic [15:0] csr_data
);

   // one transaction in flight: ready drops after an accept
   `LPN_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

   // a stalled result holds
   `LPN_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

   // a priming result carries zero rates
   `LPN_ASSERT_IMPL(a_priming_rates, clock, reset, rsp_valid && rsp_payload.priming, rsp_payload.rate_azimuth == 32'sd0 && rsp_payload.rate_elevation == 32'sd0)

   // vertical direction stays within unit range
   `LPN_ASSERT_IMPL(a_dir_up_range, clock, reset, rsp_valid, rsp_payload.dir_up <= 16'sd16384 && rsp_payload.dir_up >= -16'sd16384)

endmodule

bind image_los_proportional_navigation_core lpn_checker u_lpn_checker (.*);
